>>> hdl/stable_priority_queue_assert.svh
// assertion macros for the stable priority queue, included by spq_back
// expects clk and rst_n in the scope of the module that includes it
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SPQ_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/spq_pkg.sv
// types, sizes and codes for the stable priority queue
// used by spq_front, spq_back and stable_priority_queue
package spq_pkg;

  localparam int DEPTH         = 16;
  localparam int PAYLOAD_WIDTH = 16;
  localparam int PRIO_W        = 8;
  localparam int CMD_W         = 2;
  localparam int STATUS_W      = 2;
  localparam int CNT_W         = $clog2(DEPTH + 1);
  localparam int FIFO_DEPTH    = 2;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int FIFO_FILL_W   = $clog2(FIFO_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_ENQ     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HEAD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EXACT   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_ATLEAST = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  typedef enum logic [1:0] {
    OP_ENQ,
    OP_HEAD,
    OP_EXACT,
    OP_ATLEAST
  } op_t;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [PRIO_W-1:0]        priority_req;
    logic [PAYLOAD_WIDTH-1:0] payload;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [PRIO_W-1:0]        out_priority;
    logic [PAYLOAD_WIDTH-1:0] out_payload;
    logic [CNT_W-1:0]         count;
  } out_t;

  // decoded command as it sits in the queue between front and back
  typedef struct packed {
    op_t                      op;
    logic [PRIO_W-1:0]        key;
    logic [PAYLOAD_WIDTH-1:0] payload;
  } q_item_t;

endpackage

>>> hdl/spq_front.sv
// front end: takes input beats, decodes the command, buffers in a small fifo
// depends on spq_pkg
module spq_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  spq_pkg::in_t    in_data,
  output logic            q_valid,
  input  logic            q_ready,
  output spq_pkg::q_item_t q_item
);

  spq_pkg::q_item_t                   slot_r [spq_pkg::FIFO_DEPTH];
  logic [spq_pkg::FIFO_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [spq_pkg::FIFO_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [spq_pkg::FIFO_FILL_W-1:0]    fill_r, fill_nxt;
  spq_pkg::q_item_t                   dec;
  logic                               push, pop;

  always_comb begin
    dec.key     = in_data.priority_req;
    dec.payload = in_data.payload;
    case (in_data.cmd)
      spq_pkg::CMD_ENQ:     dec.op = spq_pkg::OP_ENQ;
      spq_pkg::CMD_HEAD:    dec.op = spq_pkg::OP_HEAD;
      spq_pkg::CMD_EXACT:   dec.op = spq_pkg::OP_EXACT;
      spq_pkg::CMD_ATLEAST: dec.op = spq_pkg::OP_ATLEAST;
      default:              dec.op = spq_pkg::OP_ENQ;
    endcase
  end

  assign in_ready = (fill_r != spq_pkg::FIFO_FILL_W'(spq_pkg::FIFO_DEPTH));
  assign q_valid  = (fill_r != '0);
  assign q_item   = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == spq_pkg::FIFO_PTR_W'(spq_pkg::FIFO_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == spq_pkg::FIFO_PTR_W'(spq_pkg::FIFO_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= dec;
    end
  end

endmodule

>>> hdl/spq_back.sv
// back end: sorted entry cells, parallel compare, shift insert/remove, result register
// depends on spq_pkg and stable_priority_queue_assert.svh
`include "stable_priority_queue_assert.svh"

module spq_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  spq_pkg::q_item_t q_item,
  output logic             out_valid,
  input  logic             out_ready,
  output spq_pkg::out_t    out_data
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t                             state_r, state_nxt;
  logic                               out_valid_r, out_valid_nxt;
  spq_pkg::out_t                      out_data_r, out_data_nxt;

  logic [spq_pkg::PRIO_W-1:0]         prio_r [spq_pkg::DEPTH];
  logic [spq_pkg::PRIO_W-1:0]         prio_nxt [spq_pkg::DEPTH];
  logic [spq_pkg::PAYLOAD_WIDTH-1:0]  pay_r [spq_pkg::DEPTH];
  logic [spq_pkg::PAYLOAD_WIDTH-1:0]  pay_nxt [spq_pkg::DEPTH];
  logic [spq_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;

  // registered compare flags and the item under work
  logic [spq_pkg::DEPTH-1:0]          ge_r, ge_nxt;
  logic [spq_pkg::DEPTH-1:0]          eq_r, eq_nxt;
  spq_pkg::q_item_t                   item_r;

  logic                               pop;
  logic                               empty, full, found;
  logic [spq_pkg::DEPTH-1:0]          sel, ins, after_sel, after_ins;
  logic                               seen_eq, seen_sel, seen_ins;
  logic [spq_pkg::PRIO_W-1:0]         rm_prio;
  logic [spq_pkg::PAYLOAD_WIDTH-1:0]  rm_pay;

  assign pop       = q_valid && q_ready;
  assign q_ready   = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a ge and an eq compare per cell against the incoming key, live cells only
  always_comb begin
    for (int i = 0; i < spq_pkg::DEPTH; i++) begin
      ge_nxt[i] = (spq_pkg::CNT_W'(i) < cnt_r) && (prio_r[i] >= q_item.key);
      eq_nxt[i] = (spq_pkg::CNT_W'(i) < cnt_r) && (prio_r[i] == q_item.key);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ge_r   <= ge_nxt;
      eq_r   <= eq_nxt;
      item_r <= q_item;
    end
  end

  // pick the cell to take out, or the slot to insert into
  always_comb begin
    empty   = (cnt_r == '0);
    full    = (cnt_r == spq_pkg::CNT_W'(spq_pkg::DEPTH));
    sel     = '0;
    ins     = '0;
    seen_eq = 1'b0;
    for (int i = 0; i < spq_pkg::DEPTH; i++) begin
      // ge flags form a prefix since cells are sorted
      ins[i] = !ge_r[i] && ((i == 0) || ge_r[(i == 0) ? 0 : i - 1]);
    end
    case (item_r.op)
      spq_pkg::OP_HEAD: begin
        sel[0] = !empty;
      end
      spq_pkg::OP_EXACT: begin
        for (int i = 0; i < spq_pkg::DEPTH; i++) begin
          sel[i]  = eq_r[i] && !seen_eq;
          seen_eq = seen_eq || eq_r[i];
        end
      end
      spq_pkg::OP_ATLEAST: begin
        for (int i = 0; i < spq_pkg::DEPTH; i++) begin
          sel[i] = ge_r[i] &&
                   ((i == spq_pkg::DEPTH - 1) ||
                    !ge_r[(i == spq_pkg::DEPTH - 1) ? i : i + 1]);
        end
      end
      default: begin
        sel = '0;
      end
    endcase
    found = |sel;
  end

  always_comb begin
    seen_sel  = 1'b0;
    seen_ins  = 1'b0;
    after_sel = '0;
    after_ins = '0;
    rm_prio   = '0;
    rm_pay    = '0;
    for (int i = 0; i < spq_pkg::DEPTH; i++) begin
      seen_sel     = seen_sel || sel[i];
      after_sel[i] = seen_sel;
      after_ins[i] = seen_ins;
      seen_ins     = seen_ins || ins[i];
      rm_prio      = rm_prio | (sel[i] ? prio_r[i] : '0);
      rm_pay       = rm_pay | (sel[i] ? pay_r[i] : '0);
    end
  end

  // next cell contents: shift up behind the insert point, down from the removed cell
  always_comb begin
    cnt_nxt = cnt_r;
    for (int i = 0; i < spq_pkg::DEPTH; i++) begin
      prio_nxt[i] = prio_r[i];
      pay_nxt[i]  = pay_r[i];
    end
    if (state_r == ST_EXEC) begin
      if (item_r.op == spq_pkg::OP_ENQ) begin
        if (!full) begin
          cnt_nxt = cnt_r + 1'b1;
          for (int i = 0; i < spq_pkg::DEPTH; i++) begin
            if (ins[i]) begin
              prio_nxt[i] = item_r.key;
              pay_nxt[i]  = item_r.payload;
            end else if (after_ins[i] && (i > 0)) begin
              prio_nxt[i] = prio_r[(i == 0) ? 0 : i - 1];
              pay_nxt[i]  = pay_r[(i == 0) ? 0 : i - 1];
            end
          end
        end
      end else if (found) begin
        cnt_nxt = cnt_r - 1'b1;
        for (int i = 0; i < spq_pkg::DEPTH - 1; i++) begin
          if (after_sel[i]) begin
            prio_nxt[i] = prio_r[i + 1];
            pay_nxt[i]  = pay_r[i + 1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < spq_pkg::DEPTH; i++) begin
      prio_r[i] <= prio_nxt[i];
      pay_r[i]  <= pay_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt                 = ST_IDLE;
        out_valid_nxt             = 1'b1;
        out_data_nxt.out_priority = '0;
        out_data_nxt.out_payload  = '0;
        out_data_nxt.count        = cnt_nxt;
        if (item_r.op == spq_pkg::OP_ENQ) begin
          out_data_nxt.status = full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
        end else if (empty) begin
          out_data_nxt.status = spq_pkg::ST_EMPTY;
        end else if (!found) begin
          out_data_nxt.status = spq_pkg::ST_NOMATCH;
        end else begin
          out_data_nxt.status       = spq_pkg::ST_OK;
          out_data_nxt.out_priority = rm_prio;
          out_data_nxt.out_payload  = rm_pay;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  `SPQ_ASSERT_NEXT(a_pop_to_exec, pop, state_r == ST_EXEC, "pop did not start execution")
  `SPQ_ASSERT(a_result_from_exec, $rose(out_valid_r), $past(state_r == ST_EXEC), "result without execution")
  `SPQ_ASSERT(a_count_bound, 1'b1, cnt_r <= spq_pkg::CNT_W'(spq_pkg::DEPTH), "entry count above depth")
  `SPQ_ASSERT_NEXT(a_count_idle, state_r == ST_IDLE, $stable(cnt_r), "count moved outside execution")

endmodule

>>> hdl/stable_priority_queue.sv
// Stable priority queue of up to 16 entries, sorted by descending priority and
// oldest first among equal priorities. Each input beat yields exactly one result
// beat. Commands enter a two-beat decode fifo; the back end then takes each
// command through its idle and exec states: on accept it compares the key against
// every cell in parallel and registers the flags, then in exec it shifts the cells
// to insert or close the gap and loads the result register. The back end takes no
// new command in exec or while a result waits to be taken.
// depends on spq_pkg, spq_front and spq_back
module stable_priority_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  spq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output spq_pkg::out_t out_data
);

  logic             q_valid;
  logic             q_ready;
  spq_pkg::q_item_t q_item;

  spq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  spq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> dv/tb_stable_priority_queue.sv
// self-checking testbench for stable_priority_queue: directed table, then random traffic
// scoreboard checks every result beat against a typed table value or a behavioral copy of the sorted store
// depends on spq_pkg and stable_priority_queue
module tb_stable_priority_queue;

  localparam int RANDOM_ITEMS = 1250;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int SCRIPT_LEN = 19;

  typedef struct {
    spq_pkg::in_t  beat;
    int unsigned   reps;
    bit            typed;
    spq_pkg::out_t want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  spq_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  spq_pkg::out_t out_data;

  // behavioral copy of the queue contents
  logic [spq_pkg::PRIO_W-1:0] slot_prio [spq_pkg::DEPTH];
  logic [spq_pkg::PAYLOAD_WIDTH-1:0] slot_tag [spq_pkg::DEPTH];
  int slot_fill = 0;

  spq_pkg::out_t pending_results [$];
  int errors = 0;
  int results_seen = 0;
  int unsigned cycle_count = 0;
  bit calm = 1'b0;

  // typed rows can be read straight off the spec; the rest go through the predictor
  script_row_t script [SCRIPT_LEN] = '{
    '{'{spq_pkg::CMD_HEAD, 8'd0, 16'h0000}, 1, 1'b1,
      '{spq_pkg::ST_EMPTY, 8'd0, 16'h0000, 5'd0}},
    '{'{spq_pkg::CMD_EXACT, 8'd255, 16'hffff}, 1, 1'b1,
      '{spq_pkg::ST_EMPTY, 8'd0, 16'h0000, 5'd0}},
    '{'{spq_pkg::CMD_ATLEAST, 8'd0, 16'h0000}, 1, 1'b1,
      '{spq_pkg::ST_EMPTY, 8'd0, 16'h0000, 5'd0}},
    '{'{spq_pkg::CMD_ENQ, 8'd0, 16'h0000}, 1, 1'b1,
      '{spq_pkg::ST_OK, 8'd0, 16'h0000, 5'd1}},
    '{'{spq_pkg::CMD_ENQ, 8'd255, 16'hffff}, 1, 1'b1,
      '{spq_pkg::ST_OK, 8'd0, 16'h0000, 5'd2}},
    '{'{spq_pkg::CMD_ENQ, 8'd128, 16'h1234}, 1, 1'b1,
      '{spq_pkg::ST_OK, 8'd0, 16'h0000, 5'd3}},
    '{'{spq_pkg::CMD_ENQ, 8'd128, 16'h5678}, 1, 1'b1,
      '{spq_pkg::ST_OK, 8'd0, 16'h0000, 5'd4}},
    '{'{spq_pkg::CMD_EXACT, 8'd7, 16'h0000}, 1, 1'b1,
      '{spq_pkg::ST_NOMATCH, 8'd0, 16'h0000, 5'd4}},
    '{'{spq_pkg::CMD_ATLEAST, 8'd255, 16'h0000}, 1, 1'b1,
      '{spq_pkg::ST_OK, 8'd255, 16'hffff, 5'd3}},
    '{'{spq_pkg::CMD_ATLEAST, 8'd255, 16'h0000}, 1, 1'b1,
      '{spq_pkg::ST_NOMATCH, 8'd0, 16'h0000, 5'd3}},
    '{'{spq_pkg::CMD_EXACT, 8'd128, 16'h0000}, 1, 1'b1,
      '{spq_pkg::ST_OK, 8'd128, 16'h1234, 5'd2}},
    '{'{spq_pkg::CMD_ATLEAST, 8'd0, 16'h0000}, 1, 1'b1,
      '{spq_pkg::ST_OK, 8'd0, 16'h0000, 5'd1}},
    '{'{spq_pkg::CMD_HEAD, 8'd0, 16'h0000}, 1, 1'b1,
      '{spq_pkg::ST_OK, 8'd128, 16'h5678, 5'd0}},
    // fill with equal priorities, payload counts up so the order shows
    '{'{spq_pkg::CMD_ENQ, 8'd200, 16'habcd}, spq_pkg::DEPTH, 1'b0, '0},
    '{'{spq_pkg::CMD_ENQ, 8'd255, 16'hffff}, 1, 1'b1,
      '{spq_pkg::ST_FULL, 8'd0, 16'h0000, 5'd16}},
    '{'{spq_pkg::CMD_ATLEAST, 8'd200, 16'h0000}, 1, 1'b0, '0},
    '{'{spq_pkg::CMD_EXACT, 8'd200, 16'h0000}, 1, 1'b0, '0},
    '{'{spq_pkg::CMD_HEAD, 8'd0, 16'h0000}, spq_pkg::DEPTH - 2, 1'b0, '0},
    '{'{spq_pkg::CMD_HEAD, 8'd0, 16'h0000}, 1, 1'b1,
      '{spq_pkg::ST_EMPTY, 8'd0, 16'h0000, 5'd0}}
  };

  stable_priority_queue u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic void pull_entry(input int pos, inout spq_pkg::out_t r);
    int i;
    r.out_priority = slot_prio[pos];
    r.out_payload = slot_tag[pos];
    for (i = pos; i + 1 < slot_fill; i++) begin
      slot_prio[i] = slot_prio[i + 1];
      slot_tag[i] = slot_tag[i + 1];
    end
    slot_fill--;
  endfunction

  function automatic spq_pkg::out_t apply_command(input spq_pkg::in_t b);
    spq_pkg::out_t r;
    int pos;
    int i;
    r = '0;
    r.status = spq_pkg::ST_OK;
    pos = 0;
    if (b.cmd == spq_pkg::CMD_ENQ) begin
      if (slot_fill >= spq_pkg::DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        while (pos < slot_fill && slot_prio[pos] >= b.priority_req) pos++;
        for (i = slot_fill; i > pos; i--) begin
          slot_prio[i] = slot_prio[i - 1];
          slot_tag[i] = slot_tag[i - 1];
        end
        slot_prio[pos] = b.priority_req;
        slot_tag[pos] = b.payload;
        slot_fill++;
      end
    end else if (slot_fill == 0) begin
      r.status = spq_pkg::ST_EMPTY;
    end else if (b.cmd == spq_pkg::CMD_HEAD) begin
      pull_entry(0, r);
    end else if (b.cmd == spq_pkg::CMD_EXACT) begin
      while (pos < slot_fill && slot_prio[pos] != b.priority_req) pos++;
      if (pos < slot_fill) pull_entry(pos, r);
      else r.status = spq_pkg::ST_NOMATCH;
    end else begin
      // last entry of the leading run at or above the key
      while (pos < slot_fill && slot_prio[pos] >= b.priority_req) pos++;
      if (pos > 0) pull_entry(pos - 1, r);
      else r.status = spq_pkg::ST_NOMATCH;
    end
    r.count = spq_pkg::CNT_W'(slot_fill);
    return r;
  endfunction

  // biased toward priorities already stored, so ties and exact hits are common
  function automatic logic [spq_pkg::PRIO_W-1:0] pick_priority();
    logic [spq_pkg::PRIO_W-1:0] p;
    p = spq_pkg::PRIO_W'($urandom_range(255));
    case ($urandom_range(3))
      1: p = spq_pkg::PRIO_W'(85 * $urandom_range(3));
      2: if (slot_fill > 0) p = slot_prio[$urandom_range(slot_fill - 1)];
      3: if (slot_fill > 0) p = slot_prio[$urandom_range(slot_fill - 1)] + spq_pkg::PRIO_W'(1);
      default: ;
    endcase
    return p;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic offer(input spq_pkg::in_t beat, input bit typed, input spq_pkg::out_t want);
    spq_pkg::out_t predicted;
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_command(beat);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  initial begin
    spq_pkg::in_t beat;
    int row;
    int k;
    int n;
    int enq_weight;
    enq_weight = 75;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (row = 0; row < SCRIPT_LEN; row++) begin
      for (k = 0; k < int'(script[row].reps); k++) begin
        beat = script[row].beat;
        if (script[row].reps > 1) beat.payload = beat.payload + spq_pkg::PAYLOAD_WIDTH'(k);
        offer(beat, script[row].typed, script[row].want);
      end
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // alternate fill-heavy and drain-heavy phases to hit full and empty
      if (n % 80 == 0) enq_weight = (enq_weight == 75) ? 25 : 75;
      calm = (n >= 300 && n < 500);
      if (n == 700) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0) @(negedge clk);
      end
      beat.payload = spq_pkg::PAYLOAD_WIDTH'($urandom_range(16'hffff));
      beat.priority_req = pick_priority();
      if ($urandom_range(99) < enq_weight) begin
        beat.cmd = spq_pkg::CMD_ENQ;
      end else begin
        case ($urandom_range(2))
          0: beat.cmd = spq_pkg::CMD_HEAD;
          1: beat.cmd = spq_pkg::CMD_EXACT;
          default: beat.cmd = spq_pkg::CMD_ATLEAST;
        endcase
      end
      offer(beat, 1'b0, '0);
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("stable_priority_queue verification clean");
    end else begin
      $display("stable_priority_queue verification failed");
    end
    $finish;
  end

  // result side backpressure, with one long hold so the input stalls
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= 150) begin
        hold_done = 1'b1;
        hold_left = 100;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!calm && $urandom_range(99) < 30) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    spq_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %p", out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          errors++;
        end
        if (out_data.out_priority !== want.out_priority) begin
          $error("out_priority: expected %0d, got %0d", want.out_priority,
                 out_data.out_priority);
          errors++;
        end
        if (out_data.out_payload !== want.out_payload) begin
          $error("out_payload: expected %h, got %h", want.out_payload, out_data.out_payload);
          errors++;
        end
        if (out_data.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_data.count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("stable_priority_queue verification failed");
      $finish;
    end
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_front.sv
hdl/spq_back.sv
hdl/stable_priority_queue.sv
dv/tb_stable_priority_queue.sv
